/* rtl/core/emwt_pkg.sv */
// ----------------------------------------------------------------------------
// emwt_pkg: shared types, constants and microcode for the elevon mixer
// Holds the register map, control word layout, fixed-point constants and the
// microprogram table read by the sequencer.
// ----------------------------------------------------------------------------
package emwt_pkg;

  // Scale constants
  localparam int STICK_FULL_SCALE = 1000;
  localparam int KNOB_UNIT        = 1000;
  localparam int MAP_DEN          = KNOB_UNIT * STICK_FULL_SCALE;

  // Reciprocals for division by constants: q = (n * RECIP) >> SHIFT,
  // then at most one upward correction.
  localparam int SHIFT_KNOB = 21;
  localparam int SHIFT_FULL = 21;
  localparam int SHIFT_MAP  = 29;
  localparam int RECIP_KNOB = (1 << SHIFT_KNOB) / KNOB_UNIT;
  localparam int RECIP_FULL = (1 << SHIFT_FULL) / STICK_FULL_SCALE;
  localparam int RECIP_MAP  = (1 << SHIFT_MAP) / MAP_DEN;

  // Register reset values
  localparam logic [7:0] LEFT_MIN_RST  = 8'd0;
  localparam logic [7:0] LEFT_MAX_RST  = 8'd180;
  localparam logic [7:0] RIGHT_MIN_RST = 8'd0;
  localparam logic [7:0] RIGHT_MAX_RST = 8'd180;
  localparam logic [7:0] IDLE_RST      = 8'd60;
  localparam logic [7:0] TOP_RST       = 8'd180;
  localparam logic [7:0] TRIM_L_RST    = 8'((9'(LEFT_MIN_RST) + 9'(LEFT_MAX_RST)) >> 1);
  localparam logic [7:0] TRIM_R_RST    = 8'((9'(RIGHT_MIN_RST) + 9'(RIGHT_MAX_RST)) >> 1);

  // Register map
  typedef enum logic [2:0] {
    CFG_LEFT_MIN  = 3'd0,
    CFG_LEFT_MAX  = 3'd1,
    CFG_RIGHT_MIN = 3'd2,
    CFG_RIGHT_MAX = 3'd3,
    CFG_IDLE      = 3'd4,
    CFG_TOP       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] left_min;
    logic [7:0] left_max;
    logic [7:0] right_min;
    logic [7:0] right_max;
    logic [7:0] idle;
    logic [7:0] top;
  } cfg_t;

  // Micro-operations of the datapath
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_THR_MUL,
    UOP_DIV_EST,
    UOP_DIV_REM,
    UOP_DIV_FIX,
    UOP_THR_SCALE,
    UOP_MOTOR_OUT,
    UOP_MIX,
    UOP_MAP_SEL,
    UOP_MAP_MUL,
    UOP_SERVO_OUT,
    UOP_TRIM,
    UOP_FAILSAFE
  } uop_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_TRIM,
    COND_LINK_BAD
  } cond_e;

  typedef enum logic [1:0] {
    DIV_KNOB,
    DIV_FULL,
    DIV_MAP
  } div_e;

  typedef enum logic {
    SIDE_LEFT,
    SIDE_RIGHT
  } side_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  localparam int PC_W = 5;

  typedef struct packed {
    uop_e            op;
    side_e           side;
    div_e            div;
    logic            floor_rnd;  // 1: round quotient to -inf, 0: toward zero
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            done;       // last step: hand the result to the output
  } ucw_t;

  typedef struct packed {
    logic is_trim;
    logic link_ok;
  } seq_flags_t;

  // Program entry points
  localparam logic [PC_W-1:0] ADDR_TRIM = 5'd25;
  localparam logic [PC_W-1:0] ADDR_FAIL = 5'd26;
  localparam logic [PC_W-1:0] ADDR_DONE = 5'd27;

  function automatic ucw_t uw(input uop_e op, input side_e side, input div_e div,
                              input logic flr, input cond_e cond,
                              input logic [PC_W-1:0] tgt, input logic done);
    ucw_t w;
    w.op        = op;
    w.side      = side;
    w.div       = div;
    w.floor_rnd = flr;
    w.cond      = cond;
    w.target    = tgt;
    w.done      = done;
    return w;
  endfunction

  // Microprogram
  function automatic ucw_t ucode_word(input logic [PC_W-1:0] pc);
    ucw_t cw;
    cw = uw(UOP_NOP, SIDE_LEFT, DIV_MAP, 1'b0, COND_NONE, '0, 1'b1);
    case (pc)
      // dispatch
      5'd0:  cw = uw(UOP_NOP,       SIDE_LEFT,  DIV_MAP,  1'b0, COND_TRIM,     ADDR_TRIM, 1'b0);
      5'd1:  cw = uw(UOP_NOP,       SIDE_LEFT,  DIV_MAP,  1'b0, COND_LINK_BAD, ADDR_FAIL, 1'b0);
      // motor: idle + trunc(min(thr*tlim/KNOB, FULL) * (top-idle) / FULL)
      5'd2:  cw = uw(UOP_THR_MUL,   SIDE_LEFT,  DIV_KNOB, 1'b0, COND_NONE,     '0,        1'b0);
      5'd3:  cw = uw(UOP_DIV_EST,   SIDE_LEFT,  DIV_KNOB, 1'b0, COND_NONE,     '0,        1'b0);
      5'd4:  cw = uw(UOP_DIV_REM,   SIDE_LEFT,  DIV_KNOB, 1'b0, COND_NONE,     '0,        1'b0);
      5'd5:  cw = uw(UOP_DIV_FIX,   SIDE_LEFT,  DIV_KNOB, 1'b0, COND_NONE,     '0,        1'b0);
      5'd6:  cw = uw(UOP_THR_SCALE, SIDE_LEFT,  DIV_FULL, 1'b0, COND_NONE,     '0,        1'b0);
      5'd7:  cw = uw(UOP_DIV_EST,   SIDE_LEFT,  DIV_FULL, 1'b0, COND_NONE,     '0,        1'b0);
      5'd8:  cw = uw(UOP_DIV_REM,   SIDE_LEFT,  DIV_FULL, 1'b0, COND_NONE,     '0,        1'b0);
      5'd9:  cw = uw(UOP_DIV_FIX,   SIDE_LEFT,  DIV_FULL, 1'b0, COND_NONE,     '0,        1'b0);
      5'd10: cw = uw(UOP_MOTOR_OUT, SIDE_LEFT,  DIV_FULL, 1'b0, COND_NONE,     '0,        1'b0);
      // left surface
      5'd11: cw = uw(UOP_MIX,       SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd12: cw = uw(UOP_MAP_SEL,   SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd13: cw = uw(UOP_MAP_MUL,   SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd14: cw = uw(UOP_DIV_EST,   SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd15: cw = uw(UOP_DIV_REM,   SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd16: cw = uw(UOP_DIV_FIX,   SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd17: cw = uw(UOP_SERVO_OUT, SIDE_LEFT,  DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      // right surface
      5'd18: cw = uw(UOP_MIX,       SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd19: cw = uw(UOP_MAP_SEL,   SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd20: cw = uw(UOP_MAP_MUL,   SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd21: cw = uw(UOP_DIV_EST,   SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd22: cw = uw(UOP_DIV_REM,   SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd23: cw = uw(UOP_DIV_FIX,   SIDE_RIGHT, DIV_MAP,  1'b1, COND_NONE,     '0,        1'b0);
      5'd24: cw = uw(UOP_SERVO_OUT, SIDE_RIGHT, DIV_MAP,  1'b1, COND_ALWAYS,   ADDR_DONE, 1'b0);
      // trim adjust and failsafe
      5'd25: cw = uw(UOP_TRIM,      SIDE_LEFT,  DIV_MAP,  1'b0, COND_ALWAYS,   ADDR_DONE, 1'b0);
      5'd26: cw = uw(UOP_FAILSAFE,  SIDE_LEFT,  DIV_MAP,  1'b0, COND_NONE,     '0,        1'b0);
      5'd27: cw = uw(UOP_NOP,       SIDE_LEFT,  DIV_MAP,  1'b0, COND_NONE,     '0,        1'b1);
      default: cw = uw(UOP_NOP, SIDE_LEFT, DIV_MAP, 1'b0, COND_NONE, '0, 1'b1);
    endcase
    return cw;
  endfunction

endpackage

/* rtl/core/elevon_mixer_with_trim.sv */
// ----------------------------------------------------------------------------
// elevon_mixer_with_trim: elevon mixer, throttle mapper and trim adjust
// Time from acceptance to result is set by the microprogram length for each
// kind of item: control update, failsafe frame and trim adjust.
// A new item is taken only once the sequencer is idle again; it runs one
// item at a time through a single shared multiply/divide datapath.
// Reset: registers take their default values, trims return to the floored
// midpoints, no result is pending.
// ----------------------------------------------------------------------------
module elevon_mixer_with_trim
  import emwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // throttle_stick, roll_stick, pitch_stick,
                                     // throttle_limit, surface_limit, buttons
  input  logic [2:0]  s_axis_tuser,  // opcode, link_connected, link_correct
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // motor_command, left_servo_angle,
                                     // right_servo_angle, beep_request
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  ucw_t       cw;
  seq_flags_t flags;
  logic       load, step_en, emit;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_MIN:  cfg_d.left_min  = cfg_data_i;
        CFG_LEFT_MAX:  cfg_d.left_max  = cfg_data_i;
        CFG_RIGHT_MIN: cfg_d.right_min = cfg_data_i;
        CFG_RIGHT_MAX: cfg_d.right_max = cfg_data_i;
        CFG_IDLE:      cfg_d.idle      = cfg_data_i;
        CFG_TOP:       cfg_d.top       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_min  <= LEFT_MIN_RST;
      cfg_q.left_max  <= LEFT_MAX_RST;
      cfg_q.right_min <= RIGHT_MIN_RST;
      cfg_q.right_max <= RIGHT_MAX_RST;
      cfg_q.idle      <= IDLE_RST;
      cfg_q.top       <= TOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // step control
  emwt_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .load_o      (load),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .flags_i     (flags),
    .cw_o        (cw),
    .step_en_o   (step_en),
    .emit_o      (emit)
  );

  // arithmetic and state
  emwt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .cfg_i       (cfg_q),
    .cw_i        (cw),
    .step_en_i   (step_en),
    .emit_i      (emit),
    .flags_o     (flags),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

/* rtl/core/emwt_sequencer.sv */
// ----------------------------------------------------------------------------
// emwt_sequencer: microprogram step counter and handshake control
// Steps through the control store, takes conditional jumps on item flags and
// holds the last step while the output register is still occupied.
// ----------------------------------------------------------------------------
module emwt_sequencer
  import emwt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       load_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  seq_flags_t flags_i,
  output ucw_t       cw_o,
  output logic       step_en_o,
  output logic       emit_o
);

  seq_state_e      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  ucw_t            cw;
  logic            take_jump;
  logic            stall;

  assign cw = ucode_word(pc_q);

  // jump condition
  always_comb begin
    case (cw.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_TRIM:     take_jump = flags_i.is_trim;
      COND_LINK_BAD: take_jump = !flags_i.link_ok;
      default:       take_jump = 1'b0;
    endcase
  end

  // last step waits while a result is still unclaimed
  assign stall = cw.done && out_valid_q && !out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = SEQ_RUN;
          pc_d    = '0;
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          if (cw.done) begin
            state_d = SEQ_IDLE;
          end else if (take_jump) begin
            pc_d = cw.target;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    step_en_o  = 1'b0;
    emit_o     = 1'b0;
    unique case (state_q)
      SEQ_IDLE: in_ready_o = 1'b1;
      SEQ_RUN: begin
        step_en_o = !stall;
        emit_o    = cw.done && !stall;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  assign load_o = in_valid_i && in_ready_o;
  assign cw_o   = cw;

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/emwt_datapath.sv */
// ----------------------------------------------------------------------------
// emwt_datapath: item capture, arithmetic registers and trim state
// One micro-operation per enabled cycle: multiply, reciprocal divide steps,
// mixing and clamping, surface map selection, trim update and result output.
// ----------------------------------------------------------------------------
module emwt_datapath
  import emwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [63:0] in_tdata_i,  // throttle, roll, pitch, tlim, slim, buttons
  input  logic [2:0]  in_tuser_i,  // opcode, link_connected, link_correct
  input  cfg_t        cfg_i,
  input  ucw_t        cw_i,
  input  logic        step_en_i,
  input  logic        emit_i,
  output seq_flags_t  flags_o,
  output logic [31:0] out_tdata_o  // motor, left angle, right angle, beep
);

  // magnitude of a 9-bit signed difference
  function automatic logic [7:0] abs9(input logic signed [8:0] v);
    logic [8:0] m;
    m = v[8] ? 9'(-v) : 9'(v);
    return m[7:0];
  endfunction

  // captured item
  logic               opcode_q, conn_q, good_q;
  logic signed [10:0] thr_q, roll_q, pitch_q;
  logic [9:0]         tlim_q, slim_q;
  logic [4:0]         btn_q;

  // working registers
  logic [28:0]        n_q, n_d;
  logic               neg_q, neg_d;
  logic [10:0]        q_q, q_d;
  logic [20:0]        r_q, r_d;
  logic signed [11:0] f_q, f_d;
  logic signed [20:0] mix_q, mix_d;
  logic [19:0]        u_q, u_d;
  logic signed [8:0]  d_q, d_d;
  logic [7:0]         base_q, base_d;

  // results, trims and output register
  logic [7:0] res_motor_q, res_motor_d;
  logic [7:0] res_left_q, res_left_d;
  logic [7:0] res_right_q, res_right_d;
  logic       res_beep_q, res_beep_d;
  logic [7:0] trim_l_q, trim_l_d;
  logic [7:0] trim_r_q, trim_r_d;
  logic [7:0] out_motor_q, out_left_q, out_right_q;
  logic       out_beep_q;

  // capture on acceptance
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      thr_q    <= in_tdata_i[10:0];
      roll_q   <= in_tdata_i[21:11];
      pitch_q  <= in_tdata_i[32:22];
      tlim_q   <= in_tdata_i[42:33];
      slim_q   <= in_tdata_i[52:43];
      btn_q    <= in_tdata_i[57:53];
      opcode_q <= in_tuser_i[0];
      conn_q   <= in_tuser_i[1];
      good_q   <= in_tuser_i[2];
    end
  end

  assign flags_o.is_trim = opcode_q;
  assign flags_o.link_ok = conn_q && good_q;

  // divisor constants
  logic [19:0] dv;
  logic [11:0] recip;
  logic [4:0]  dsh;
  always_comb begin
    case (cw_i.div)
      DIV_KNOB: begin
        dv = 20'(KNOB_UNIT); recip = 12'(RECIP_KNOB); dsh = 5'(SHIFT_KNOB);
      end
      DIV_FULL: begin
        dv = 20'(STICK_FULL_SCALE); recip = 12'(RECIP_FULL); dsh = 5'(SHIFT_FULL);
      end
      default: begin
        dv = 20'(MAP_DEN); recip = 12'(RECIP_MAP); dsh = 5'(SHIFT_MAP);
      end
    endcase
  end

  // quotient estimate, remainder and correction
  logic [40:0]        div_prod;
  logic [30:0]        qd_prod, rem_full;
  logic               rem_ge;
  logic [11:0]        q_corr, mag;
  logic [20:0]        rem_corr;
  logic signed [11:0] f_fix;
  always_comb begin
    div_prod = 41'(n_q) * 41'(recip);
    qd_prod  = 31'(q_q) * 31'(dv);
    rem_full = 31'(n_q) - qd_prod;
    rem_ge   = r_q >= 21'(dv);
    q_corr   = rem_ge ? 12'(q_q) + 12'd1 : 12'(q_q);
    rem_corr = rem_ge ? r_q - 21'(dv) : r_q;
    mag      = q_corr + 12'(cw_i.floor_rnd && neg_q && (rem_corr != '0));
    f_fix    = neg_q ? -$signed(mag) : $signed(mag);
  end

  // throttle terms
  logic              thr_pos;
  logic [10:0]       x_sat;
  logic signed [8:0] mdiff;
  always_comb begin
    thr_pos = !thr_q[10] && (thr_q != '0);
    x_sat   = (f_q > $signed(12'(STICK_FULL_SCALE))) ? 11'(STICK_FULL_SCALE) : f_q[10:0];
    mdiff   = $signed({1'b0, cfg_i.top}) - $signed({1'b0, cfg_i.idle});
  end

  // mixing and side selection
  logic signed [12:0] mix_sum;
  logic signed [23:0] mix_prod;
  logic [7:0]         s_lo, s_hi, s_mid;
  always_comb begin
    if (cw_i.side == SIDE_RIGHT) begin
      mix_sum = -(13'(pitch_q) + 13'(roll_q));
      s_lo    = cfg_i.right_min;
      s_hi    = cfg_i.right_max;
      s_mid   = trim_r_q;
    end else begin
      mix_sum = 13'(pitch_q) - 13'(roll_q);
      s_lo    = cfg_i.left_min;
      s_hi    = cfg_i.left_max;
      s_mid   = trim_l_q;
    end
    mix_prod = 24'(mix_sum) * $signed({14'b0, slim_q});
  end

  // trim adjust
  logic signed [9:0] tl_v, tr_v;
  logic [7:0]        tl_new, tr_new;
  always_comb begin
    tl_v = $signed({2'b0, trim_l_q});
    if (btn_q[0]) begin
      tl_v = tl_v - 10'sd1;
    end else if (btn_q[1]) begin
      tl_v = tl_v + 10'sd1;
    end
    tr_v = $signed({2'b0, trim_r_q});
    if (btn_q[2]) begin
      tr_v = tr_v + 10'sd1;
    end else if (btn_q[3]) begin
      tr_v = tr_v - 10'sd1;
    end
    if (tl_v < $signed({2'b0, cfg_i.left_min})) begin
      tl_new = cfg_i.left_min;
    end else if (tl_v > $signed({2'b0, cfg_i.left_max})) begin
      tl_new = cfg_i.left_max;
    end else begin
      tl_new = tl_v[7:0];
    end
    if (tr_v < $signed({2'b0, cfg_i.right_min})) begin
      tr_new = cfg_i.right_min;
    end else if (tr_v > $signed({2'b0, cfg_i.right_max})) begin
      tr_new = cfg_i.right_max;
    end else begin
      tr_new = tr_v[7:0];
    end
  end

  // micro-operation execution
  always_comb begin
    n_d         = n_q;
    neg_d       = neg_q;
    q_d         = q_q;
    r_d         = r_q;
    f_d         = f_q;
    mix_d       = mix_q;
    u_d         = u_q;
    d_d         = d_q;
    base_d      = base_q;
    res_motor_d = res_motor_q;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_beep_d  = res_beep_q;
    trim_l_d    = trim_l_q;
    trim_r_d    = trim_r_q;
    if (step_en_i) begin
      case (cw_i.op)
        UOP_THR_MUL: begin
          n_d   = thr_pos ? 29'(thr_q[9:0]) * 29'(tlim_q) : '0;
          neg_d = 1'b0;
        end
        UOP_DIV_EST: q_d = 11'(div_prod >> dsh);
        UOP_DIV_REM: r_d = rem_full[20:0];
        UOP_DIV_FIX: f_d = f_fix;
        UOP_THR_SCALE: begin
          n_d   = 29'(x_sat) * 29'(abs9(mdiff));
          neg_d = mdiff[8];
        end
        UOP_MOTOR_OUT: begin
          res_motor_d = cfg_i.idle + f_q[7:0];
          res_beep_d  = 1'b0;
        end
        UOP_MIX: begin
          if (mix_prod > $signed(24'(MAP_DEN))) begin
            mix_d = $signed(21'(MAP_DEN));
          end else if (mix_prod < -$signed(24'(MAP_DEN))) begin
            mix_d = -$signed(21'(MAP_DEN));
          end else begin
            mix_d = mix_prod[20:0];
          end
        end
        UOP_MAP_SEL: begin
          if (!mix_q[20]) begin
            u_d    = mix_q[19:0];
            d_d    = $signed({1'b0, s_hi}) - $signed({1'b0, s_mid});
            base_d = s_mid;
          end else begin
            u_d    = 20'(mix_q + $signed(21'(MAP_DEN)));
            d_d    = $signed({1'b0, s_mid}) - $signed({1'b0, s_lo});
            base_d = s_lo;
          end
        end
        UOP_MAP_MUL: begin
          n_d   = 29'(u_q) * 29'(abs9(d_q));
          neg_d = d_q[8];
        end
        UOP_SERVO_OUT: begin
          if (cw_i.side == SIDE_RIGHT) begin
            res_right_d = base_q + f_q[7:0];
          end else begin
            res_left_d = base_q + f_q[7:0];
          end
        end
        UOP_TRIM: begin
          trim_l_d    = tl_new;
          trim_r_d    = tr_new;
          res_motor_d = cfg_i.idle;
          res_left_d  = tl_new;
          res_right_d = tr_new;
          res_beep_d  = btn_q[4];
        end
        UOP_FAILSAFE: begin
          res_motor_d = cfg_i.idle;
          res_left_d  = trim_l_q;
          res_right_d = trim_r_q;
          res_beep_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    neg_q       <= neg_d;
    q_q         <= q_d;
    r_q         <= r_d;
    f_q         <= f_d;
    mix_q       <= mix_d;
    u_q         <= u_d;
    d_q         <= d_d;
    base_q      <= base_d;
    res_motor_q <= res_motor_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_beep_q  <= res_beep_d;
  end

  // trim midpoints
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_l_q <= TRIM_L_RST;
      trim_r_q <= TRIM_R_RST;
    end else begin
      trim_l_q <= trim_l_d;
      trim_r_q <= trim_r_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      out_motor_q <= res_motor_q;
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
      out_beep_q  <= res_beep_q;
    end
  end

  assign out_tdata_o = {7'b0, out_beep_q, out_right_q, out_left_q, out_motor_q};

endmodule

/* sim/elevon_mixer_with_trim_test.sv */
// ----------------------------------------------------------------------------
// elevon_mixer_with_trim_test: self-checking bench for the elevon mixer
// Feeds control, failsafe and trim frames in random bursts and compares every
// servo/motor command with an exact integer mix computed alongside, over
// several register settings including swapped and full-scale limits.
// ----------------------------------------------------------------------------
module elevon_mixer_with_trim_test;
  import emwt_pkg::*;

  typedef enum logic {
    OP_CONTROL = 1'b0,
    OP_TRIM    = 1'b1
  } frame_op_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  // Button masks
  localparam logic [4:0] KEY_L1 = 5'b00001;
  localparam logic [4:0] KEY_L2 = 5'b00010;
  localparam logic [4:0] KEY_R1 = 5'b00100;
  localparam logic [4:0] KEY_R2 = 5'b01000;
  localparam logic [4:0] KEY_OK = 5'b10000;
  localparam logic [4:0] KEY_NONE = 5'b00000;

  // Indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 700;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES = 7;

  typedef struct {
    frame_op_e          op;
    logic               conn;
    logic               good;
    logic signed [10:0] thr;
    logic signed [10:0] roll;
    logic signed [10:0] pitch;
    logic [9:0]         tlim;
    logic [9:0]         slim;
    logic [4:0]         keys;
  } frame_t;

  typedef struct {
    logic [7:0] motor;
    logic [7:0] left;
    logic [7:0] right;
    logic       beep;
  } servo_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // throttle, roll, pitch, tlim, slim, buttons
  logic [2:0]  s_axis_tuser = '0;  // opcode, link_connected, link_correct
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // motor, left angle, right angle, beep
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_LEFT_MIN;
  logic [7:0]  cfg_data_i = '0;

  elevon_mixer_with_trim DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow registers and trims
  logic [7:0] lmin_q = LEFT_MIN_RST, lmax_q = LEFT_MAX_RST;
  logic [7:0] rmin_q = RIGHT_MIN_RST, rmax_q = RIGHT_MAX_RST;
  logic [7:0] idle_q = IDLE_RST, top_q = TOP_RST;
  logic [7:0] trim_l = TRIM_L_RST, trim_r = TRIM_R_RST;

  frame_t     frames_pending[$];
  servo_cmd_t cmds_expected[$];
  frame_t     cur_frame;

  int errors = 0;
  int frames_sent = 0, trims_sent = 0, failsafes_sent = 0;
  int results_seen = 0, reg_writes = 0;
  int burst_left = 1, gap_left = 0;
  int hold_left = 0, mode_left = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  logic [7:0] stall_pat = 8'b1011_0010;
  int idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- prediction ----------------------------------------------------------

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Piecewise map of a clamped mix (millionths) onto a servo angle
  function automatic logic [7:0] surface_angle(input longint v, input longint lo,
                                               input longint mid, input longint hi);
    longint den, r;
    den = longint'(MAP_DEN);
    if (v >= 0) r = mid + floor_quot(v * (hi - mid), den);
    else r = lo + floor_quot((v + den) * (mid - lo), den);
    return r[7:0];
  endfunction

  function automatic longint clamp_mix(input longint v);
    longint lim;
    lim = longint'(MAP_DEN);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [7:0] clamp_trim(input int v, input int lo, input int hi);
    if (v < lo) return 8'(lo);
    if (v > hi) return 8'(hi);
    return 8'(v);
  endfunction

  // Command that a frame produces; moves the trims on a trim adjust
  function automatic servo_cmd_t mix_frame(input frame_t f);
    servo_cmd_t c;
    longint thr, roll, pitch, tl, sl, x, m, lv, rv, idle, top;
    int l, r;
    thr = f.thr; roll = f.roll; pitch = f.pitch;
    tl = f.tlim; sl = f.slim;
    idle = idle_q; top = top_q;
    c.motor = idle_q;
    c.left = trim_l;
    c.right = trim_r;
    c.beep = 1'b0;
    if (f.op == OP_TRIM) begin
      l = trim_l;
      r = trim_r;
      if (f.keys & KEY_L1) l = l - 1;
      else if (f.keys & KEY_L2) l = l + 1;
      if (f.keys & KEY_R1) r = r + 1;
      else if (f.keys & KEY_R2) r = r - 1;
      trim_l = clamp_trim(l, lmin_q, lmax_q);
      trim_r = clamp_trim(r, rmin_q, rmax_q);
      c.left = trim_l;
      c.right = trim_r;
      c.beep = (f.keys & KEY_OK) != 0;
    end else if (f.conn && f.good) begin
      if (thr > 0) begin
        x = (thr * tl) / KNOB_UNIT;
        if (x > STICK_FULL_SCALE) x = STICK_FULL_SCALE;
        m = idle + (x * (top - idle)) / STICK_FULL_SCALE;
        c.motor = m[7:0];
      end
      lv = clamp_mix(pitch * sl - roll * sl);
      rv = clamp_mix(pitch * sl + roll * sl);
      c.left = surface_angle(lv, lmin_q, trim_l, lmax_q);
      c.right = surface_angle(-rv, rmin_q, trim_r, rmax_q);
    end
    return c;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  task automatic queue_frame(input frame_op_e op, input logic conn, input logic good,
                             input int thr, input int roll, input int pitch,
                             input int tlim, input int slim, input logic [4:0] keys);
    frame_t f;
    f.op = op; f.conn = conn; f.good = good;
    f.thr = 11'(thr); f.roll = 11'(roll); f.pitch = 11'(pitch);
    f.tlim = 10'(tlim); f.slim = 10'(slim); f.keys = keys;
    frames_pending.push_back(f);
  endtask

  function automatic logic signed [10:0] random_stick();
    case ($urandom_range(0, 7))
      0: return -11'sd1024;
      1: return 11'sd1023;
      2: return 11'sd0;
      3: return $urandom_range(0, 1) ? 11'sd1000 : -11'sd1000;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [9:0] random_knob();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1000;
      2: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Mostly live control frames, some trim adjusts and some failsafe frames
  function automatic frame_t random_frame();
    frame_t f;
    int kind;
    logic [1:0] link;
    kind = $urandom_range(0, 99);
    f.op = (kind < 15) ? OP_TRIM : OP_CONTROL;
    link = 2'b11;
    if (kind < 15) link = 2'($urandom_range(0, 3));
    else if (kind < 28) link = 2'($urandom_range(0, 2));
    f.conn = link[1];
    f.good = link[0];
    f.thr = random_stick();
    f.roll = random_stick();
    f.pitch = random_stick();
    f.tlim = random_knob();
    f.slim = random_knob();
    f.keys = 5'($urandom_range(0, 31));
    return f;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_LEFT_MIN:  lmin_q = val;
      CFG_LEFT_MAX:  lmax_q = val;
      CFG_RIGHT_MIN: rmin_q = val;
      CFG_RIGHT_MAX: rmax_q = val;
      CFG_IDLE:      idle_q = val;
      CFG_TOP:       top_q = val;
      default: ;
    endcase
  endtask

  task automatic write_limits(input int lmin, input int lmax, input int rmin,
                              input int rmax, input int idle, input int top);
    write_reg(CFG_LEFT_MIN, 8'(lmin));
    write_reg(CFG_LEFT_MAX, 8'(lmax));
    write_reg(CFG_RIGHT_MIN, 8'(rmin));
    write_reg(CFG_RIGHT_MAX, 8'(rmax));
    write_reg(CFG_IDLE, 8'(idle));
    write_reg(CFG_TOP, 8'(top));
  endtask

  task automatic wait_drained();
    while (frames_pending.size() != 0 || s_axis_tvalid || cmds_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch at result %0d: %s expected %0d got %0d",
             results_seen, what, want, got);
    errors++;
  endtask

  // ---- frame driver: bursts with random gaps -------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cmds_expected.push_back(mix_frame(cur_frame));
        frames_sent++;
        if (cur_frame.op == OP_TRIM) trims_sent++;
        else if (!(cur_frame.conn && cur_frame.good)) failsafes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (frames_pending.size() != 0) begin
          cur_frame = frames_pending.pop_front();
          s_axis_tdata <= {6'b0, cur_frame.keys, cur_frame.slim, cur_frame.tlim,
                           cur_frame.pitch, cur_frame.roll, cur_frame.thr};
          s_axis_tuser <= {cur_frame.good, cur_frame.conn, cur_frame.op};
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor and receiver stalls ----------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (cmds_expected.size() == 0) begin
          report_mismatch("result with nothing pending, word", 0, m_axis_tdata);
        end else begin
          servo_cmd_t want;
          want = cmds_expected.pop_front();
          if (m_axis_tdata[7:0] !== want.motor)
            report_mismatch("motor_command", want.motor, m_axis_tdata[7:0]);
          if (m_axis_tdata[15:8] !== want.left)
            report_mismatch("left_servo_angle", want.left, m_axis_tdata[15:8]);
          if (m_axis_tdata[23:16] !== want.right)
            report_mismatch("right_servo_angle", want.right, m_axis_tdata[23:16]);
          if (m_axis_tdata[24] !== want.beep)
            report_mismatch("beep_request", want.beep, m_axis_tdata[24]);
        end
        // long back-pressure so the block fills up and stalls its input
        if (results_seen == 400 || results_seen == 1300) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
          stall_pat = 8'($urandom_range(0, 255)) | 8'b1;
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            m_axis_tready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
          end
        endcase
      end
    end
  end

  // ---- watchdog: cycles with no transfer on any channel --------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- test sequence -------------------------------------------------------
  initial begin : stimulus
    int phase_items;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at reset settings
    queue_frame(OP_CONTROL, 1, 1, 1000, 0, 0, 1000, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 0, 0, 0, 1000, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, -1024, 0, 0, 1023, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 1023, 0, 0, 1023, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 500, 0, 1000, 0, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 1, -1024, 1023, 1, 1023, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 700, 1023, -1024, 1023, 1023, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 300, 1000, 0, 500, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, 300, 1023, 1023, 500, 0, KEY_NONE);
    queue_frame(OP_CONTROL, 0, 1, 1000, 1000, 1000, 1000, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 0, 1000, -1000, 1000, 1000, 1000, KEY_NONE);
    queue_frame(OP_CONTROL, 0, 0, 1023, -1024, -1024, 1023, 1023, 5'b11111);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_L1);
    queue_frame(OP_TRIM, 0, 0, 0, 0, 0, 0, 0, KEY_L2);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_L1 | KEY_L2);
    queue_frame(OP_TRIM, 1, 0, 0, 0, 0, 0, 0, KEY_R1);
    queue_frame(OP_TRIM, 0, 1, 0, 0, 0, 0, 0, KEY_R2);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_R1 | KEY_R2);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_OK);
    queue_frame(OP_TRIM, 1, 1, 1023, -1024, 1023, 1023, 1023, 5'b11111);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_NONE);
    queue_frame(OP_TRIM, 1, 1, 0, 0, 0, 0, 0, KEY_L2 | KEY_R2 | KEY_OK);
    queue_frame(OP_CONTROL, 1, 1, 500, -300, 500, 300, 700, KEY_NONE);
    queue_frame(OP_CONTROL, 1, 1, -1, 999, -999, 999, 999, KEY_NONE);

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (phase)
        1: begin
          write_limits($urandom_range(0, 180), $urandom_range(0, 180),
                       $urandom_range(0, 180), $urandom_range(0, 180),
                       $urandom_range(0, 180), $urandom_range(0, 180));
          phase_items = 300;
        end
        2: begin
          // swapped right side, idle above top
          write_limits(0, 255, 255, 0, 255, 0);
          phase_items = 250;
        end
        3: begin
          // narrow ranges force trim clamping; spare indexes must be ignored
          write_limits(88, 92, 0, 0, 0, 180);
          write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
          write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
          phase_items = 250;
        end
        4: begin
          write_limits(255, 255, 180, 180, 180, 180);
          phase_items = 200;
        end
        5: begin
          write_limits($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
          phase_items = 400;
        end
        default: begin
          write_limits(LEFT_MIN_RST, LEFT_MAX_RST, RIGHT_MIN_RST, RIGHT_MAX_RST,
                       IDLE_RST, TOP_RST);
          phase_items = 500;
        end
      endcase
      repeat (phase_items) frames_pending.push_back(random_frame());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d frames (%0d trim adjusts, %0d with link down or bad), %0d results",
             frames_sent, trims_sent, failsafes_sent, results_seen);
    $display("Register writes: %0d over %0d settings incl. swapped and full-scale limits",
             reg_writes, NUM_PHASES);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
